>>> src/tcwsq_pkg.sv
// shared types and constants of the two-class weighted service queue
// used by the channel interfaces, top level, front, back and testbench; depends on nothing
package tcwsq_pkg;

    localparam int NUM_SERVERS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TAG_BITS_DEF    = 16;

    localparam int SERVER_W    = 2;
    localparam int TAG_W       = 16;
    localparam int COUNT_W     = 6;
    localparam int BURST_W     = 4;
    localparam int CAP_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int STATUS_W    = 2;

    localparam int CMD_FIFO_DEPTH = 2;

    localparam logic [BURST_W-1:0] BURST_RESET = 4'd2;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 6'd15;

    localparam logic MODE_ADD       = 1'b0;
    localparam logic MODE_SERVE     = 1'b1;
    localparam logic CLASS_NORMAL   = 1'b0;
    localparam logic CLASS_PRIORITY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED  = 2'd0,
        ST_FULL   = 2'd1,
        ST_SERVED = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } ram_op_t;

    typedef struct packed {
        status_t              status;
        logic                 served_class;
        logic [COUNT_W-1:0]   normal_waiting;
        logic [COUNT_W-1:0]   priority_waiting;
    } cmd_meta_t;

endpackage

>>> src/tcwsq_req_if.sv
// request channel: one add or serve item per beat
// depends on tcwsq_pkg
interface tcwsq_req_if;
    import tcwsq_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [SERVER_W-1:0] server;
    logic [TAG_W-1:0]    entry_tag;
    logic                priority_class;

    modport source (output valid, mode, server, entry_tag, priority_class, input ready);
    modport sink   (input valid, mode, server, entry_tag, priority_class, output ready);
endinterface

>>> src/tcwsq_rsp_if.sv
// response channel: one result per beat
// depends on tcwsq_pkg
interface tcwsq_rsp_if;
    import tcwsq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    served_tag;
    logic                served_class;
    logic [COUNT_W-1:0]  normal_waiting;
    logic [COUNT_W-1:0]  priority_waiting;

    modport source (output valid, status, served_tag, served_class, normal_waiting,
                    priority_waiting, input ready);
    modport sink   (input valid, status, served_tag, served_class, normal_waiting,
                    priority_waiting, output ready);
endinterface

>>> src/tcwsq_cfg_if.sv
// configuration write channel: register index and data per beat
// depends on tcwsq_pkg
interface tcwsq_cfg_if;
    import tcwsq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/two_class_weighted_service_queue.sv
// top level of the two-class weighted service queue
// depends on tcwsq_pkg, the three channel interfaces, tcwsq_front, tcwsq_cmd_fifo, tcwsq_back
//
//   channel  dir  payload
//   req      in   mode, server, entry_tag, priority_class
//   rsp      out  status, served_tag, served_class, normal_waiting, priority_waiting
//   cfg      in   index (0 priority_burst, 1 server_capacity), data
//
// one item per cycle sustained while rsp is not stalled, set by the single port of the tag store ram
// an accepted item passes through the command queue, stage one and the result register to rsp
// reset clears counts, pointers and streak at once; tag store needs no clearing pass
// a stall on rsp backs up into the two-entry command queue, then drops req.ready
// cfg.ready is always high
module two_class_weighted_service_queue #(
    parameter int NUM_SERVERS = tcwsq_pkg::NUM_SERVERS_DEF,
    parameter int QUEUE_DEPTH = tcwsq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tcwsq_pkg::TAG_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tcwsq_req_if.sink   req,
    tcwsq_rsp_if.source rsp,
    tcwsq_cfg_if.sink   cfg
);
    import tcwsq_pkg::*;

    localparam int STORE_W   = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int RAM_DEPTH = 2 * NUM_SERVERS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int CMD_W     = $bits(ram_op_t) + ADDR_W + STORE_W + $bits(cmd_meta_t);

    logic               f_valid, f_ready;
    ram_op_t            f_op, b_op;
    logic [ADDR_W-1:0]  f_addr, b_addr;
    logic [STORE_W-1:0] f_wdata, b_wdata;
    cmd_meta_t          f_meta, b_meta;
    logic               b_valid, b_ready;
    logic [CMD_W-1:0]   q_in, q_out;

    tcwsq_front #(
        .NUM_SERVERS (NUM_SERVERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_op    (f_op),
        .cmd_addr  (f_addr),
        .cmd_wdata (f_wdata),
        .cmd_meta  (f_meta)
    );

    assign q_in = {f_op, f_addr, f_wdata, f_meta};

    tcwsq_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    assign {b_op, b_addr, b_wdata, b_meta} = q_out;

    tcwsq_back #(
        .STORE_W   (STORE_W),
        .RAM_DEPTH (RAM_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_op    (b_op),
        .cmd_addr  (b_addr),
        .cmd_wdata (b_wdata),
        .cmd_meta  (b_meta),
        .rsp       (rsp)
    );
endmodule

>>> src/tcwsq_ram.sv
// generic single-port ram with registered read
// depends on nothing
module tcwsq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> src/tcwsq_cmd_fifo.sv
// short command queue between the classifying front and the storage back
// depends on nothing
module tcwsq_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule

>>> src/tcwsq_front.sv
// front: accepts items, keeps pointers, counts, streak and config, and issues commands
// depends on tcwsq_pkg, tcwsq_req_if, tcwsq_cfg_if
module tcwsq_front #(
    parameter int NUM_SERVERS = tcwsq_pkg::NUM_SERVERS_DEF,
    parameter int QUEUE_DEPTH = tcwsq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tcwsq_pkg::TAG_BITS_DEF,
    localparam int STORE_W = (TAG_BITS < tcwsq_pkg::TAG_W) ? TAG_BITS : tcwsq_pkg::TAG_W,
    localparam int ADDR_W  = $clog2(2 * NUM_SERVERS * QUEUE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    tcwsq_req_if.sink           req,
    tcwsq_cfg_if.sink           cfg,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output tcwsq_pkg::ram_op_t  cmd_op,
    output logic [ADDR_W-1:0]   cmd_addr,
    output logic [STORE_W-1:0]  cmd_wdata,
    output tcwsq_pkg::cmd_meta_t cmd_meta
);
    import tcwsq_pkg::*;

    localparam int SRV_IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);

    logic [COUNT_W-1:0] cnt_n_reg  [NUM_SERVERS];
    logic [COUNT_W-1:0] cnt_p_reg  [NUM_SERVERS];
    logic [PTR_W-1:0]   head_n_reg [NUM_SERVERS];
    logic [PTR_W-1:0]   head_p_reg [NUM_SERVERS];
    logic [PTR_W-1:0]   tail_n_reg [NUM_SERVERS];
    logic [PTR_W-1:0]   tail_p_reg [NUM_SERVERS];
    logic [BURST_W-1:0] streak_reg, streak_next;
    logic [BURST_W-1:0] burst_reg;
    logic [CAP_W-1:0]   cap_reg;

    logic [SRV_IDX_W-1:0] sidx;
    logic                 in_range;
    logic                 acc;
    logic [COUNT_W-1:0]   cn, cp, cn_next, cp_next;
    logic [PTR_W-1:0]     hn, hp, tn, tp;
    logic [PTR_W-1:0]     hn_next, hp_next, tn_next, tp_next;
    logic [COUNT_W:0]     total;
    logic                 full;
    logic                 want_pri, take_pri;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SRV_IDX_W-1:0] s,
                                                  input logic c,
                                                  input logic [PTR_W-1:0] p);
        return ADDR_W'({s, c}) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    assign sidx      = SRV_IDX_W'(req.server);
    assign in_range  = int'(req.server) < NUM_SERVERS;
    assign req.ready = cmd_ready;
    assign cmd_valid = req.valid;
    assign acc       = req.valid && cmd_ready;
    assign cfg.ready = 1'b1;

    assign cn    = cnt_n_reg[sidx];
    assign cp    = cnt_p_reg[sidx];
    assign hn    = head_n_reg[sidx];
    assign hp    = head_p_reg[sidx];
    assign tn    = tail_n_reg[sidx];
    assign tp    = tail_p_reg[sidx];
    assign total = {1'b0, cn} + {1'b0, cp};
    // effective capacity is the smaller of the setting and the queue depth
    assign full  = (int'(total) >= int'(cap_reg)) || (int'(total) >= QUEUE_DEPTH);

    assign want_pri = streak_reg < burst_reg;
    assign take_pri = want_pri ? (cp != '0) : (cn == '0);

    always_comb
    begin
        cn_next     = cn;
        cp_next     = cp;
        hn_next     = hn;
        hp_next     = hp;
        tn_next     = tn;
        tp_next     = tp;
        streak_next = streak_reg;
        cmd_op      = OP_NONE;
        cmd_addr    = '0;
        cmd_wdata   = req.entry_tag[STORE_W-1:0];
        cmd_meta    = '{status: ST_FULL, served_class: CLASS_NORMAL,
                        normal_waiting: '0, priority_waiting: '0};
        if (!in_range)
        begin
            cmd_meta.status = (req.mode == MODE_SERVE) ? ST_EMPTY : ST_FULL;
        end
        else if (req.mode == MODE_ADD)
        begin
            if (!full)
            begin
                cmd_meta.status = ST_ADDED;
                cmd_op          = OP_WRITE;
                if (req.priority_class == CLASS_PRIORITY)
                begin
                    cmd_addr = addr_of(sidx, CLASS_PRIORITY, tp);
                    tp_next  = ptr_inc(tp);
                    cp_next  = cp + 1'b1;
                end
                else
                begin
                    cmd_addr = addr_of(sidx, CLASS_NORMAL, tn);
                    tn_next  = ptr_inc(tn);
                    cn_next  = cn + 1'b1;
                end
            end
            cmd_meta.normal_waiting   = cn_next;
            cmd_meta.priority_waiting = cp_next;
        end
        else if (cn == '0 && cp == '0)
        begin
            cmd_meta.status = ST_EMPTY;
        end
        else
        begin
            cmd_meta.status       = ST_SERVED;
            cmd_meta.served_class = take_pri;
            cmd_op                = OP_READ;
            if (take_pri)
            begin
                cmd_addr = addr_of(sidx, CLASS_PRIORITY, hp);
                hp_next  = ptr_inc(hp);
                cp_next  = cp - 1'b1;
                // saturate at burst; a streak left above a lowered burst stays put
                if (streak_reg < burst_reg)
                begin
                    streak_next = streak_reg + 1'b1;
                end
            end
            else
            begin
                cmd_addr    = addr_of(sidx, CLASS_NORMAL, hn);
                hn_next     = ptr_inc(hn);
                cn_next     = cn - 1'b1;
                streak_next = '0;
            end
            cmd_meta.normal_waiting   = cn_next;
            cmd_meta.priority_waiting = cp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                cnt_n_reg[i]  <= '0;
                cnt_p_reg[i]  <= '0;
                head_n_reg[i] <= '0;
                head_p_reg[i] <= '0;
                tail_n_reg[i] <= '0;
                tail_p_reg[i] <= '0;
            end
            streak_reg <= '0;
            burst_reg  <= BURST_RESET;
            cap_reg    <= CAP_RESET;
        end
        else
        begin
            if (acc && in_range)
            begin
                cnt_n_reg[sidx]  <= cn_next;
                cnt_p_reg[sidx]  <= cp_next;
                head_n_reg[sidx] <= hn_next;
                head_p_reg[sidx] <= hp_next;
                tail_n_reg[sidx] <= tn_next;
                tail_p_reg[sidx] <= tp_next;
                streak_reg       <= streak_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_BURST:    burst_reg <= cfg.data[BURST_W-1:0];
                    CFG_CAPACITY: cap_reg   <= cfg.data[CAP_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_range |-> int'(total) <= QUEUE_DEPTH)
        else $error("server holds more entries than the queue depth");

    a_range_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !in_range |-> cmd_op == OP_NONE)
        else $error("out of range server touched the tag store");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        acc && cmd_op == OP_READ |=> $past(cn) != '0 || $past(cp) != '0)
        else $error("serve read issued on an empty server");
`endif
endmodule

>>> src/tcwsq_back.sv
// back: runs tag store writes and reads and holds the result register
// depends on tcwsq_pkg, tcwsq_rsp_if, tcwsq_ram
module tcwsq_back #(
    parameter int STORE_W   = 16,
    parameter int RAM_DEPTH = 256,
    localparam int ADDR_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  tcwsq_pkg::ram_op_t   cmd_op,
    input  logic [ADDR_W-1:0]    cmd_addr,
    input  logic [STORE_W-1:0]   cmd_wdata,
    input  tcwsq_pkg::cmd_meta_t cmd_meta,
    tcwsq_rsp_if.source          rsp
);
    import tcwsq_pkg::*;

    logic             s1_valid_reg;
    logic             s1_read_reg;
    cmd_meta_t        s1_meta_reg;
    logic             out_valid_reg;
    cmd_meta_t        out_meta_reg;
    logic [TAG_W-1:0] out_tag_reg;

    logic               pop, s1_move, ram_we, ram_re;
    logic [STORE_W-1:0] ram_rdata;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd_ready = !s1_valid_reg || s1_move;
    assign pop       = cmd_valid && cmd_ready;
    assign ram_we    = pop && (cmd_op == OP_WRITE);
    // read only on pop so the read data holds while stage one waits
    assign ram_re    = pop && (cmd_op == OP_READ);

    tcwsq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (RAM_DEPTH)
    ) u_tag_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (cmd_addr),
        .wdata (cmd_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_read_reg <= (cmd_op == OP_READ);
            s1_meta_reg <= cmd_meta;
        end
        if (s1_move)
        begin
            out_meta_reg <= s1_meta_reg;
            out_tag_reg  <= s1_read_reg ? TAG_W'(ram_rdata) : '0;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_meta_reg.status;
    assign rsp.served_tag       = out_tag_reg;
    assign rsp.served_class     = out_meta_reg.served_class;
    assign rsp.normal_waiting   = out_meta_reg.normal_waiting;
    assign rsp.priority_waiting = out_meta_reg.priority_waiting;

`ifndef SYNTHESIS
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_SERVED |-> rsp.served_tag == '0 && !rsp.served_class)
        else $error("tag or class set on a beat that served nothing");

    a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> s1_valid_reg && s1_read_reg)
        else $error("tag read issued without stage one tracking it");

    a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_read_reg && !s1_move |-> !ram_re && !ram_we)
        else $error("tag store accessed while a read result waits");
`endif
endmodule

>>> sim/two_class_weighted_service_queue_tb.sv
// testbench for the two-class weighted service queue: directed and random add/serve traffic
// predicts every result in-line and compares each rsp beat field by field
// depends on tcwsq_pkg, the req/rsp/cfg channel interfaces and the top level
`timescale 1ns / 1ps

module two_class_weighted_service_queue_tb;
    import tcwsq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_PCT     = 34;
    localparam int NQUEUES      = NUM_SERVERS_DEF * 2;
    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH_DEF);

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        status_t            status;
        logic [TAG_W-1:0]   tag;
        logic               cls;
        logic [COUNT_W-1:0] nw;
        logic [COUNT_W-1:0] pw;
    } outcome_t;

    logic clk;
    logic rst_n;

    tcwsq_req_if req_ch ();
    tcwsq_rsp_if rsp_ch ();
    tcwsq_cfg_if cfg_ch ();

    two_class_weighted_service_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicted queue state
    logic [TAG_W-1:0]   tag_mem   [NQUEUES][DEPTH];
    logic [PTR_W-1:0]   head_ptr  [NQUEUES];
    logic [PTR_W-1:0]   tail_ptr  [NQUEUES];
    logic [COUNT_W-1:0] entry_cnt [NQUEUES];
    logic [BURST_W-1:0] pri_streak;
    logic [BURST_W-1:0] burst_cfg;
    logic [CAP_W-1:0]   cap_cfg;

    outcome_t pending_outcomes [$];
    int       mismatches;
    int       items_sent;
    int       beats_seen;
    int       cycle_count;
    bit       no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at beat %0d: %s", beats_seen, msg);
        mismatches++;
    endtask

    function automatic outcome_t predict_outcome(input logic mode,
                                                 input logic [SERVER_W-1:0] server,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic cls);
        outcome_t res;
        int       nq;
        int       pq;
        int       q;
        int       cap;
        int       held;
        logic     take_pri;
        res = '0;
        if (int'(server) >= NUM_SERVERS_DEF)
        begin
            res.status = (mode == MODE_SERVE) ? ST_EMPTY : ST_FULL;
            return res;
        end
        nq = int'(server) * 2;
        pq = nq + 1;
        if (mode == MODE_ADD)
        begin
            cap  = (int'(cap_cfg) > DEPTH) ? DEPTH : int'(cap_cfg);
            held = int'(entry_cnt[nq]) + int'(entry_cnt[pq]);
            if (held >= cap)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                q = (cls == CLASS_PRIORITY) ? pq : nq;
                tag_mem[q][tail_ptr[q]] = tag;
                tail_ptr[q]  = tail_ptr[q] + 1'b1;
                entry_cnt[q] = entry_cnt[q] + 1'b1;
                res.status   = ST_ADDED;
            end
            res.nw = entry_cnt[nq];
            res.pw = entry_cnt[pq];
            return res;
        end
        if (entry_cnt[nq] == 0 && entry_cnt[pq] == 0)
        begin
            res.status = ST_EMPTY;
            return res;
        end
        // fall back to the other class when the preferred one is empty
        if (pri_streak < burst_cfg)
            take_pri = (entry_cnt[pq] != 0);
        else
            take_pri = (entry_cnt[nq] == 0);
        q = take_pri ? pq : nq;
        res.tag      = tag_mem[q][head_ptr[q]];
        head_ptr[q]  = head_ptr[q] + 1'b1;
        entry_cnt[q] = entry_cnt[q] - 1'b1;
        if (take_pri)
        begin
            if (pri_streak < burst_cfg)
                pri_streak = pri_streak + 1'b1;
        end
        else
        begin
            pri_streak = '0;
        end
        res.status = ST_SERVED;
        res.cls    = take_pri ? CLASS_PRIORITY : CLASS_NORMAL;
        res.nw     = entry_cnt[nq];
        res.pw     = entry_cnt[pq];
        return res;
    endfunction

    task automatic send_item(input logic mode, input logic [SERVER_W-1:0] server,
                             input logic [TAG_W-1:0] tag, input logic cls);
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= mode;
        req_ch.server         <= server;
        req_ch.entry_tag      <= tag;
        req_ch.priority_class <= cls;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_outcomes.push_back(predict_outcome(mode, server, tag, cls));
        items_sent++;
    endtask

    // stop traffic and let every outstanding result come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_BURST)
            burst_cfg = data[BURST_W-1:0];
        else if (idx == CFG_CAPACITY)
            cap_cfg = data;
    endtask

    task automatic check_outcome();
        outcome_t want;
        if (pending_outcomes.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                      rsp_ch.status));
            return;
        end
        want = pending_outcomes.pop_front();
        if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
        if (rsp_ch.served_tag !== want.tag)
            report_mismatch($sformatf("served_tag got %h want %h", rsp_ch.served_tag, want.tag));
        if (rsp_ch.served_class !== want.cls)
            report_mismatch($sformatf("served_class got %b want %b",
                                      rsp_ch.served_class, want.cls));
        if (rsp_ch.normal_waiting !== want.nw)
            report_mismatch($sformatf("normal_waiting got %0d want %0d",
                                      rsp_ch.normal_waiting, want.nw));
        if (rsp_ch.priority_waiting !== want.pw)
            report_mismatch($sformatf("priority_waiting got %0d want %0d",
                                      rsp_ch.priority_waiting, want.pw));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            beats_seen++;
            check_outcome();
        end
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // reset values: burst of two, capacity fifteen
    task automatic test_default_settings();
        send_item(MODE_SERVE, 2'd3, 16'h0000, CLASS_NORMAL);
        send_item(MODE_ADD, 2'd0, 16'h0000, CLASS_NORMAL);
        send_item(MODE_ADD, 2'd0, 16'hFFFF, CLASS_PRIORITY);
        send_item(MODE_ADD, 2'd0, 16'h1234, CLASS_PRIORITY);
        send_item(MODE_ADD, 2'd0, 16'h0F0F, CLASS_PRIORITY);
        // two priority, then normal wins, then priority again
        repeat (4) send_item(MODE_SERVE, 2'd0, 16'hFFFF, CLASS_PRIORITY);
    endtask

    task automatic test_capacity_limits();
        write_reg(CFG_CAPACITY, 6'd0);
        send_item(MODE_ADD, 2'd2, 16'hA5A5, CLASS_NORMAL);
        write_reg(CFG_CAPACITY, 6'd1);
        send_item(MODE_ADD, 2'd2, 16'h5A5A, CLASS_PRIORITY);
        send_item(MODE_ADD, 2'd2, 16'h8001, CLASS_NORMAL);
        send_item(MODE_SERVE, 2'd2, 16'h0000, CLASS_NORMAL);
    endtask

    task automatic test_burst_zero();
        write_reg(CFG_BURST, 6'd0);
        write_reg(CFG_CAPACITY, 6'd15);
        send_item(MODE_ADD, 2'd1, 16'h7777, CLASS_PRIORITY);
        send_item(MODE_ADD, 2'd1, 16'h8888, CLASS_NORMAL);
        // normal always preferred, priority only once normal is empty
        repeat (2) send_item(MODE_SERVE, 2'd1, 16'h0000, CLASS_NORMAL);
    endtask

    task automatic test_streak_over_burst();
        write_reg(CFG_BURST, 6'd15);
        send_item(MODE_ADD, 2'd3, 16'h0101, CLASS_PRIORITY);
        send_item(MODE_ADD, 2'd3, 16'h0202, CLASS_PRIORITY);
        send_item(MODE_ADD, 2'd3, 16'h0303, CLASS_PRIORITY);
        repeat (3) send_item(MODE_SERVE, 2'd3, 16'h0000, CLASS_NORMAL);
        // streak now three, above the lowered burst
        write_reg(CFG_BURST, 6'd1);
        send_item(MODE_ADD, 2'd3, 16'h0404, CLASS_PRIORITY);
        send_item(MODE_SERVE, 2'd3, 16'h0000, CLASS_NORMAL);
        send_item(MODE_ADD, 2'd3, 16'h0505, CLASS_NORMAL);
        send_item(MODE_ADD, 2'd3, 16'h0606, CLASS_PRIORITY);
        repeat (2) send_item(MODE_SERVE, 2'd3, 16'h0000, CLASS_NORMAL);
    endtask

    task automatic test_spare_registers();
        write_reg(CFG_SPARE_A, 6'h3F);
        write_reg(CFG_SPARE_B, 6'h2A);
        send_item(MODE_ADD, 2'd0, 16'hC3C3, CLASS_NORMAL);
        send_item(MODE_SERVE, 2'd0, 16'h0000, CLASS_NORMAL);
    endtask

    task automatic test_random_traffic();
        int                    phase;
        int                    start_count;
        int                    len;
        int                    add_pct;
        int                    pri_pct;
        int                    n;
        bit                    focused;
        logic [SERVER_W-1:0]   focus_srv;
        logic [SERVER_W-1:0]   srv;
        logic                  mode;
        logic [TAG_W-1:0]      tag_val;
        logic [CFG_DATA_W-1:0] burst_val;
        logic [CFG_DATA_W-1:0] cap_val;
        phase       = 0;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            // upper data bits ride along on burst writes
            burst_val = CFG_DATA_W'($urandom);
            case (phase % 4)
                0: burst_val[BURST_W-1:0] = '0;
                1: burst_val[BURST_W-1:0] = '1;
                default: ;
            endcase
            case (phase % 5)
                0: cap_val = 6'd32;
                1: cap_val = 6'd63;
                2: cap_val = 6'd1;
                3: cap_val = CFG_DATA_W'($urandom_range(1, 32));
                default: cap_val = CFG_DATA_W'($urandom_range(0, 63));
            endcase
            if ($urandom_range(1))
            begin
                write_reg(CFG_BURST, burst_val);
                write_reg(CFG_CAPACITY, cap_val);
            end
            else
            begin
                write_reg(CFG_CAPACITY, cap_val);
                write_reg(CFG_BURST, burst_val);
            end
            no_idle   = (phase % 6 == 5);
            len       = $urandom_range(60, 160);
            add_pct   = $urandom_range(55, 90);
            pri_pct   = $urandom_range(10, 90);
            focused   = ($urandom_range(2) == 0);
            focus_srv = SERVER_W'($urandom);
            for (n = 0; n < len; n++)
            begin
                srv     = focused ? focus_srv : SERVER_W'($urandom);
                tag_val = TAG_W'($urandom);
                // fill during the first half, drain during the second
                if (n < len / 2)
                    mode = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_SERVE;
                else
                    mode = ($urandom_range(99) < 100 - add_pct) ? MODE_ADD : MODE_SERVE;
                send_item(mode, srv, tag_val,
                          ($urandom_range(99) < pri_pct) ? CLASS_PRIORITY : CLASS_NORMAL);
            end
            no_idle = 1'b0;
            phase++;
        end
    endtask

    initial
    begin
        int i;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.mode           = MODE_ADD;
        req_ch.server         = '0;
        req_ch.entry_tag      = '0;
        req_ch.priority_class = CLASS_NORMAL;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_BURST;
        cfg_ch.data           = '0;
        mismatches            = 0;
        items_sent            = 0;
        beats_seen            = 0;
        cycle_count           = 0;
        no_idle               = 1'b0;
        for (i = 0; i < NQUEUES; i++)
        begin
            head_ptr[i]  = '0;
            tail_ptr[i]  = '0;
            entry_cnt[i] = '0;
        end
        pri_streak = '0;
        burst_cfg  = BURST_RESET;
        cap_cfg    = CAP_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_settings();
        test_capacity_limits();
        test_burst_zero();
        test_streak_over_burst();
        test_spare_registers();
        test_random_traffic();

        settle();
        repeat (8) @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
